/* rtl/core/mdrt_pkg.sv */
// Shared types, widths and codes for the microtile dirty region tracker.
`timescale 1ns / 1ps

package mdrt_pkg;

   // default grid geometry
   localparam int TILE_SHIFT_DEF = 5;
   localparam int MAX_COLS_DEF   = 32;
   localparam int MAX_ROWS_DEF   = 32;

   // surface size registers and clipped coordinates
   localparam int COORD_W = 11;
   localparam logic [COORD_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [COORD_W-1:0] HEIGHT_RESET = 11'd480;

   // command codes
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;

   // result field widths
   localparam int BOX_POS_W = 10;
   localparam int BOX_LEN_W = 6;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] rect_x;
      logic signed [15:0] rect_y;
      logic [15:0]        rect_w;
      logic [15:0]        rect_h;
      logic [4:0]         tile_row;
      logic [4:0]         tile_col;
   } req_type;

   typedef struct packed {
      logic                 tile_dirty;
      logic [BOX_POS_W-1:0] box_x;
      logic [BOX_POS_W-1:0] box_y;
      logic [BOX_LEN_W-1:0] box_w;
      logic [BOX_LEN_W-1:0] box_h;
   } rsp_type;

   // rectangle after clipping, end exclusive
   typedef struct packed {
      logic               empty;
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y1;
   } clip_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_ADD_SETUP,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_READ_WAIT
   } state_type;

endpackage

/* rtl/core/mdrt_tile_ram.sv */
// Tile box store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module mdrt_tile_ram #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 24,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/mdrt_clip.sv */
// Clips an add rectangle against the effective surface, registered.
`timescale 1ns / 1ps

module mdrt_clip (
   input  logic                           clock,
   input  logic                           load,
   input  mdrt_pkg::req_type              req,
   input  logic [mdrt_pkg::COORD_W-1:0]   eff_w,
   input  logic [mdrt_pkg::COORD_W-1:0]   eff_h,
   output mdrt_pkg::clip_type             clip
);
   import mdrt_pkg::*;

   logic signed [17:0] xs, ys, ws, hs, xe, ye, lim_x, lim_y;
   logic signed [17:0] x0c, y0c, x1c, y1c;
   clip_type           clip_ff, clip_in;

   always_comb begin
      xs    = 18'(req.rect_x);
      ys    = 18'(req.rect_y);
      ws    = signed'({2'b00, req.rect_w});
      hs    = signed'({2'b00, req.rect_h});
      xe    = xs + ws;
      ye    = ys + hs;
      lim_x = signed'({7'd0, eff_w});
      lim_y = signed'({7'd0, eff_h});
      x0c   = xs[17] ? 18'sd0 : xs;
      y0c   = ys[17] ? 18'sd0 : ys;
      x1c   = (xe > lim_x) ? lim_x : xe;
      y1c   = (ye > lim_y) ? lim_y : ye;

      // once non-empty all four lie within the surface
      clip_in.empty = (req.rect_w == 16'd0) || (req.rect_h == 16'd0) ||
                      (x0c >= x1c) || (y0c >= y1c);
      clip_in.x0 = x0c[COORD_W-1:0];
      clip_in.y0 = y0c[COORD_W-1:0];
      clip_in.x1 = x1c[COORD_W-1:0];
      clip_in.y1 = y1c[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         clip_ff <= clip_in;
      end
   end

   assign clip = clip_ff;

endmodule

/* rtl/core/mdrt_merge.sv */
// Overlap of the clipped rectangle with one tile, merged into the old box.
`timescale 1ns / 1ps

module mdrt_merge #(
   parameter int TILE_SHIFT = 5,
   parameter int COL_W      = 5,
   parameter int ROW_W      = 5
) (
   input  mdrt_pkg::clip_type         clip,
   input  logic [ROW_W-1:0]           row,
   input  logic [COL_W-1:0]           col,
   input  logic [4*(TILE_SHIFT+1)-1:0] old_box,
   output logic [4*(TILE_SHIFT+1)-1:0] new_box
);
   import mdrt_pkg::*;

   localparam int OFF_W  = TILE_SHIFT + 1;
   localparam int TILE   = 1 << TILE_SHIFT;
   localparam int GRID_W = ((COL_W > ROW_W) ? COL_W : ROW_W) + TILE_SHIFT;
   localparam int W      = ((COORD_W > GRID_W) ? COORD_W : GRID_W) + 1;

   logic [W-1:0]     tx, ty, x0, y0, x1, y1;
   logic [OFF_W-1:0] a0, b0, a1, b1, o0, p0, o1, p1;

   always_comb begin
      tx = W'(col) << TILE_SHIFT;
      ty = W'(row) << TILE_SHIFT;
      x0 = W'(clip.x0);
      y0 = W'(clip.y0);
      x1 = W'(clip.x1);
      y1 = W'(clip.y1);

      a0 = (x0 > tx) ? OFF_W'(x0 - tx) : '0;
      b0 = (y0 > ty) ? OFF_W'(y0 - ty) : '0;
      a1 = (x1 < tx + W'(TILE)) ? OFF_W'(x1 - tx) : OFF_W'(TILE);
      b1 = (y1 < ty + W'(TILE)) ? OFF_W'(y1 - ty) : OFF_W'(TILE);

      o0 = old_box[4*OFF_W-1 -: OFF_W];
      p0 = old_box[3*OFF_W-1 -: OFF_W];
      o1 = old_box[2*OFF_W-1 -: OFF_W];
      p1 = old_box[OFF_W-1:0];

      // a clean tile takes the overlap as it stands
      if (old_box != '0) begin
         if (o0 < a0) a0 = o0;
         if (p0 < b0) b0 = p0;
         if (o1 > a1) a1 = o1;
         if (p1 > b1) b1 = p1;
      end

      new_box = {a0, b0, a1, b1};
   end

endmodule

/* rtl/core/microtile_dirty_region_tracker.sv */
// Top level of the microtile dirty region tracker: control, registers and store.
`timescale 1ns / 1ps

// Screen dirty-region tracker over a grid of square tiles.
//
// Commands: a command transfer takes place at a clock edge with start high
// and busy low. Add clips a rectangle to the surface and grows the dirty box
// of every tile it touches; read reports one tile's absolute dirty box;
// clear makes every tile clean; the unused code does nothing.
// Every command gives exactly one result: rsp_valid is high for one cycle
// with rsp_payload, and the receiver must take it then (no back-pressure).
// Busy stays high from a command transfer until that command is done, so no
// new command is taken before then; the result strobe falls in the first
// cycle in which the next command can be transferred.
// Add: one read and one write-back of the tile store for each touched tile,
// since the store has a single port pair; an empty add touches no tile.
// Read: one store read. Clear: one store entry zeroed a cycle.
// Surface registers: csr_ready is always high; write them only while idle.
// Reset restores the surface registers to 640 x 480 and starts a clearing
// pass over all MAX_ROWS*MAX_COLS entries (1024 by default) with busy high;
// that pass gives no result, and register writes are still taken during it.
module microtile_dirty_region_tracker #(
   parameter int TILE_SHIFT = mdrt_pkg::TILE_SHIFT_DEF,
   parameter int MAX_COLS   = mdrt_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS   = mdrt_pkg::MAX_ROWS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              start,
   output logic                              busy,
   input  mdrt_pkg::req_type                 req_payload,
   // result channel
   output logic                              rsp_valid,
   output mdrt_pkg::rsp_type                 rsp_payload,
   // surface registers
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mdrt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mdrt_pkg::COORD_W-1:0]      csr_wdata
);
   import mdrt_pkg::*;

   localparam int TILE       = 1 << TILE_SHIFT;
   localparam int OFF_W      = TILE_SHIFT + 1;
   localparam int DATA_W     = 4 * OFF_W;
   localparam int TILE_COUNT = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W     = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
   localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int LIM_X      = MAX_COLS << TILE_SHIFT;
   localparam int LIM_Y      = MAX_ROWS << TILE_SHIFT;
   localparam int CNT_W      = COORD_W + 1;

   // surface registers
   logic [COORD_W-1:0] width_ff, height_ff;
   logic [COORD_W-1:0] eff_w, eff_h;
   logic [CNT_W-1:0]   cols_avail, rows_avail;

   // control
   state_type          state_ff, state_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic               sweep_rsp_ff, sweep_rsp_in;
   logic               read_ok_ff, read_ok_in;
   logic [4:0]         rd_row_ff, rd_row_in, rd_col_ff, rd_col_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // datapath
   logic               accept, clip_load;
   clip_type           clip;
   logic [ROW_W-1:0]   row_first, row_last;
   logic [COL_W-1:0]   col_first, col_last;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr, walk_addr, req_addr;
   logic [DATA_W-1:0]  wr_data, rd_data, merged;
   logic [OFF_W-1:0]   bx0, by0, bx1, by1;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_WIDTH)  width_ff  <= csr_wdata;
         if (csr_index == CSR_HEIGHT) height_ff <= csr_wdata;
      end
   end

   // surface limited to what the grid covers
   assign eff_w = (32'(width_ff)  < LIM_X) ? width_ff  : COORD_W'(LIM_X);
   assign eff_h = (32'(height_ff) < LIM_Y) ? height_ff : COORD_W'(LIM_Y);
   assign cols_avail = (CNT_W'(eff_w) + CNT_W'(TILE - 1)) >> TILE_SHIFT;
   assign rows_avail = (CNT_W'(eff_h) + CNT_W'(TILE - 1)) >> TILE_SHIFT;

   assign clip_load = accept && (req_payload.cmd == CMD_ADD);

   mdrt_clip u_clip (
      .clock (clock),
      .load  (clip_load),
      .req   (req_payload),
      .eff_w (eff_w),
      .eff_h (eff_h),
      .clip  (clip)
   );

   // tile span of the clipped rectangle
   assign row_first = ROW_W'(clip.y0 >> TILE_SHIFT);
   assign row_last  = ROW_W'((clip.y1 - COORD_W'(1)) >> TILE_SHIFT);
   assign col_first = COL_W'(clip.x0 >> TILE_SHIFT);
   assign col_last  = COL_W'((clip.x1 - COORD_W'(1)) >> TILE_SHIFT);

   assign walk_addr = ADDR_W'(row_ff * MAX_COLS) + ADDR_W'(col_ff);
   assign req_addr  = ADDR_W'(req_payload.tile_row * MAX_COLS) +
                      ADDR_W'(req_payload.tile_col);
   assign rd_addr   = (state_ff == ST_IDLE) ? req_addr : walk_addr;

   mdrt_merge #(
      .TILE_SHIFT (TILE_SHIFT),
      .COL_W      (COL_W),
      .ROW_W      (ROW_W)
   ) u_merge (
      .clip    (clip),
      .row     (row_ff),
      .col     (col_ff),
      .old_box (rd_data),
      .new_box (merged)
   );

   // write-back of a walked tile, or zero during a clearing pass
   assign wr_en   = (state_ff == ST_ADD_WR) || (state_ff == ST_SWEEP);
   assign wr_addr = (state_ff == ST_SWEEP) ? sweep_ff : walk_addr;
   assign wr_data = (state_ff == ST_SWEEP) ? '0 : merged;

   mdrt_tile_ram #(
      .DEPTH  (TILE_COUNT),
      .DATA_W (DATA_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign bx0 = rd_data[4*OFF_W-1 -: OFF_W];
   assign by0 = rd_data[3*OFF_W-1 -: OFF_W];
   assign bx1 = rd_data[2*OFF_W-1 -: OFF_W];
   assign by1 = rd_data[OFF_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff     <= row_in;
      col_ff     <= col_in;
      read_ok_ff <= read_ok_in;
      rd_row_ff  <= rd_row_in;
      rd_col_ff  <= rd_col_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      sweep_in     = sweep_ff;
      sweep_rsp_in = sweep_rsp_ff;
      read_ok_in   = read_ok_ff;
      rd_row_in    = rd_row_ff;
      rd_col_in    = rd_col_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;

      case (state_ff)
         ST_SWEEP: begin
            sweep_in = sweep_ff + ADDR_W'(1);
            if (sweep_ff == ADDR_W'(TILE_COUNT - 1)) begin
               sweep_in     = '0;
               rsp_valid_in = sweep_rsp_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_payload.cmd)
                  CMD_ADD: begin
                     state_in = ST_ADD_SETUP;
                  end
                  CMD_READ: begin
                     read_ok_in = (CNT_W'(req_payload.tile_row) < rows_avail) &&
                                  (CNT_W'(req_payload.tile_col) < cols_avail);
                     rd_row_in  = req_payload.tile_row;
                     rd_col_in  = req_payload.tile_col;
                     state_in   = ST_READ_WAIT;
                  end
                  CMD_CLEAR: begin
                     sweep_in     = '0;
                     sweep_rsp_in = 1'b1;
                     state_in     = ST_SWEEP;
                  end
                  default: begin
                     // unused code: nothing changes, zero result
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_ADD_SETUP: begin
            if (clip.empty) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               row_in   = row_first;
               col_in   = col_first;
               state_in = ST_ADD_RD;
            end
         end
         ST_ADD_RD: begin
            state_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            // raster walk, the write lands before the next read is issued
            state_in = ST_ADD_RD;
            if (col_ff == col_last) begin
               col_in = col_first;
               if (row_ff == row_last) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         ST_READ_WAIT: begin
            rsp_valid_in = 1'b1;
            if (read_ok_ff && (rd_data != '0)) begin
               rsp_in.tile_dirty = 1'b1;
               rsp_in.box_x = BOX_POS_W'((32'(rd_col_ff) << TILE_SHIFT) + 32'(bx0));
               rsp_in.box_y = BOX_POS_W'((32'(rd_row_ff) << TILE_SHIFT) + 32'(by0));
               rsp_in.box_w = BOX_LEN_W'(bx1 - bx0);
               rsp_in.box_h = BOX_LEN_W'(by1 - by0);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/mdrt_checker.sv */
// Port-level checks on the tracker and their binding to the top level.
`timescale 1ns / 1ps

module mdrt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input mdrt_pkg::req_type                 req_payload,
   input logic                              rsp_valid,
   input mdrt_pkg::rsp_type                 rsp_payload,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [mdrt_pkg::CSR_IDX_W-1:0]    csr_index,
   input logic [mdrt_pkg::COORD_W-1:0]      csr_wdata
);
   import mdrt_pkg::*;

   // reset starts the clearing pass and drops any result
   a_reset_clears: assert property (@(posedge clock)
      reset |=> busy && !rsp_valid)
      else $error("tracker not busy or result shown after reset");

   // a command transfer either occupies the block or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("command transfer neither started work nor answered");

   // a result follows work in progress or a command just taken
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result with no command outstanding");

   // a clean answer carries no box
   a_clean_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.tile_dirty) |->
         (rsp_payload.box_x == '0) && (rsp_payload.box_y == '0) &&
         (rsp_payload.box_w == '0) && (rsp_payload.box_h == '0))
      else $error("box fields set on a clean result");

endmodule

bind microtile_dirty_region_tracker mdrt_checker u_mdrt_checker (.*);

/* test/tb_top.sv */
// Self-checking testbench for the microtile dirty region tracker.
`timescale 1ns / 1ps

module tb_top;
   import mdrt_pkg::*;

   // grid geometry as built
   localparam int TSHIFT = TILE_SHIFT_DEF;
   localparam int TSIZE  = 1 << TSHIFT;
   localparam int NCOLS  = MAX_COLS_DEF;
   localparam int NROWS  = MAX_ROWS_DEF;
   localparam int OFFW   = TSHIFT + 1;     // one tile-relative offset
   localparam int BOXW   = 4 * OFFW;       // x0, y0, x1, y1, x0 highest

   // the one command code the package leaves unnamed: does nothing
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam rsp_type NO_BOX = '0;

   // phases of random commands, one surface size each
   localparam int N_PHASES  = 9;
   localparam int PHASE_LEN = 200;
   // quiet cycles at the end in which no stray result may turn up
   localparam int SETTLE_CYCLES = 100;
   // hard stop, well beyond the slowest legal run (clears and full-screen adds)
   localparam int RUN_LIMIT_NS = 200_000_000;

   typedef struct {
      req_type req;
      bit      pinned;   // result typed in below rather than predicted
      rsp_type want;
   } dir_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_payload;
   logic              rsp_valid;
   rsp_type           rsp_payload;
   logic              csr_valid;
   logic              csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0]   csr_wdata;

   // shadow of the block: surface registers and the tile store
   logic [COORD_W-1:0] surf_w;
   logic [COORD_W-1:0] surf_h;
   logic [BOXW-1:0]    tile_box [NROWS*NCOLS];

   // results still owed by the block, oldest first
   rsp_type rsp_due [$];
   int      fail_count;

   // hand-over from the driver to the monitor for typed-in results
   bit      hold_pinned;
   rsp_type pinned_rsp;

   dir_row_type dir_rows [27];
   int          plan_w [N_PHASES];
   int          plan_h [N_PHASES];

   microtile_dirty_region_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow model of the tile grid
   // ---------------------------------------------------------------------

   // surface size after the grid cap; zero leaves no screen at all
   function automatic int eff_size(logic [COORD_W-1:0] reg_v, int cap);
      return (int'(reg_v) < cap) ? int'(reg_v) : cap;
   endfunction

   // k = 0..3 picks x0, y0, x1, y1
   function automatic int box_off(logic [BOXW-1:0] b, int k);
      return int'(b[(3-k)*OFFW +: OFFW]);
   endfunction

   // applies one command to the shadow grid, returns the result it gives
   function automatic rsp_type run_command(req_type r);
      rsp_type         res;
      int              sw, sh, x0, y0, x1, y1, tr, tc, a0, b0, a1, b1;
      int              nrows, ncols, idx;
      logic [BOXW-1:0] cur;
      res = NO_BOX;
      sw  = eff_size(surf_w, NCOLS * TSIZE);
      sh  = eff_size(surf_h, NROWS * TSIZE);
      case (r.cmd)
         CMD_ADD: begin
            x0 = int'(r.rect_x);
            y0 = int'(r.rect_y);
            x1 = x0 + int'(r.rect_w);
            y1 = y0 + int'(r.rect_h);
            // a negative edge just shortens the rectangle by the off-screen part
            if (x0 < 0) x0 = 0;
            if (y0 < 0) y0 = 0;
            if (x1 > sw) x1 = sw;
            if (y1 > sh) y1 = sh;
            if (r.rect_w != 0 && r.rect_h != 0 && x0 < x1 && y0 < y1) begin
               for (tr = y0 >>> TSHIFT; tr <= (y1 - 1) >>> TSHIFT; tr++) begin
                  for (tc = x0 >>> TSHIFT; tc <= (x1 - 1) >>> TSHIFT; tc++) begin
                     // overlap with this tile, tile-relative, end exclusive
                     a0 = (x0 > tc*TSIZE) ? x0 - tc*TSIZE : 0;
                     b0 = (y0 > tr*TSIZE) ? y0 - tr*TSIZE : 0;
                     a1 = (x1 < (tc+1)*TSIZE) ? x1 - tc*TSIZE : TSIZE;
                     b1 = (y1 < (tr+1)*TSIZE) ? y1 - tr*TSIZE : TSIZE;
                     idx = tr*NCOLS + tc;
                     cur = tile_box[idx];
                     // all-zero entry means clean: nothing to merge with
                     if (cur != '0) begin
                        if (box_off(cur, 0) < a0) a0 = box_off(cur, 0);
                        if (box_off(cur, 1) < b0) b0 = box_off(cur, 1);
                        if (box_off(cur, 2) > a1) a1 = box_off(cur, 2);
                        if (box_off(cur, 3) > b1) b1 = box_off(cur, 3);
                     end
                     tile_box[idx] = {OFFW'(a0), OFFW'(b0), OFFW'(a1), OFFW'(b1)};
                  end
               end
            end
         end
         CMD_READ: begin
            nrows = (sh + TSIZE - 1) >>> TSHIFT;
            ncols = (sw + TSIZE - 1) >>> TSHIFT;
            // tiles past the current grid read as clean
            if (int'(r.tile_row) < nrows && int'(r.tile_col) < ncols) begin
               cur = tile_box[int'(r.tile_row)*NCOLS + int'(r.tile_col)];
               if (cur != '0) begin
                  res.tile_dirty = 1'b1;
                  res.box_x = BOX_POS_W'(int'(r.tile_col)*TSIZE + box_off(cur, 0));
                  res.box_y = BOX_POS_W'(int'(r.tile_row)*TSIZE + box_off(cur, 1));
                  res.box_w = BOX_LEN_W'(box_off(cur, 2) - box_off(cur, 0));
                  res.box_h = BOX_LEN_W'(box_off(cur, 3) - box_off(cur, 1));
               end
            end
         end
         CMD_CLEAR: begin
            foreach (tile_box[i]) tile_box[i] = '0;
         end
         default: ;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Command builders
   // ---------------------------------------------------------------------

   function automatic req_type mk_add(int x, int y, int w, int h);
      req_type r;
      r        = '0;
      r.cmd    = CMD_ADD;
      r.rect_x = 16'(x);
      r.rect_y = 16'(y);
      r.rect_w = 16'(w);
      r.rect_h = 16'(h);
      return r;
   endfunction

   function automatic req_type mk_read(int row, int col);
      req_type r;
      r          = '0;
      r.cmd      = CMD_READ;
      r.tile_row = 5'(row);
      r.tile_col = 5'(col);
      return r;
   endfunction

   function automatic req_type mk_op(logic [1:0] code);
      req_type r;
      r     = '0;
      r.cmd = code;
      return r;
   endfunction

   function automatic rsp_type mk_box(int x, int y, int w, int h);
      rsp_type b;
      b.tile_dirty = 1'b1;
      b.box_x      = BOX_POS_W'(x);
      b.box_y      = BOX_POS_W'(y);
      b.box_w      = BOX_LEN_W'(w);
      b.box_h      = BOX_LEN_W'(h);
      return b;
   endfunction

   // Random command, shaped by the current surface: mostly small rectangles
   // around the screen and reads of tiles inside the grid, a few full-screen
   // adds, clears, unused codes and raw noise for the wide field bits.
   function automatic req_type random_cmd();
      req_type      r;
      logic [95:0]  noise;
      int           sel, sw, sh, nrows, ncols;
      noise = {$urandom, $urandom, $urandom};
      r     = noise[$bits(req_type)-1:0];
      sw    = eff_size(surf_w, NCOLS * TSIZE);
      sh    = eff_size(surf_h, NROWS * TSIZE);
      nrows = (sh + TSIZE - 1) >>> TSHIFT;
      ncols = (sw + TSIZE - 1) >>> TSHIFT;
      sel   = $urandom_range(0, 999);
      if (sel < 20) begin
         r.cmd = CMD_CLEAR;
      end else if (sel < 40) begin
         r.cmd = CMD_UNUSED;
      end else if (sel < 70) begin
         r.cmd = CMD_ADD;             // raw 16-bit edges and sizes
      end else if (sel < 85) begin
         r.cmd    = CMD_ADD;          // from at or off the top-left corner, at least screen size
         r.rect_x = 16'(-int'($urandom_range(0, 48)));
         r.rect_y = 16'(-int'($urandom_range(0, 48)));
         r.rect_w = 16'(sw + int'($urandom_range(0, 96)));
         r.rect_h = 16'(sh + int'($urandom_range(0, 96)));
      end else if (sel < 600) begin
         r.cmd    = CMD_ADD;
         r.rect_x = 16'(int'($urandom_range(0, sw + 48)) - 48);
         r.rect_y = 16'(int'($urandom_range(0, sh + 48)) - 48);
         r.rect_w = 16'($urandom_range(0, 72));
         r.rect_h = 16'($urandom_range(0, 72));
      end else begin
         r.cmd = CMD_READ;
         // now and then keep the raw row/column, often off the grid
         if ($urandom_range(0, 15) != 0) begin
            r.tile_row = 5'($urandom_range(0, (nrows > 0) ? nrows - 1 : 0));
            r.tile_col = 5'($urandom_range(0, (ncols > 0) ? ncols - 1 : 0));
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driving: change on the falling edge, transfers on the rising edge
   // ---------------------------------------------------------------------

   // presents one command and returns at the edge of its transfer
   task automatic issue(input req_type r, input bit pin, input rsp_type pin_val);
      @(negedge clock);
      hold_pinned = pin;
      pinned_rsp  = pin_val;
      start       <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // start low for an idle stretch whose length n gives
   task automatic idle_cycles(input int n);
      if (n > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // stop sending until every owed result is in and the block is idle
   task automatic wait_quiet();
      idle_cycles(1);
      @(posedge clock);
      while (rsp_due.size() != 0 || busy) @(posedge clock);
   endtask

   // writes both surface registers, one transfer each, back to back
   task automatic set_surface(input int w, input int h);
      int k;
      for (k = 0; k < 2; k++) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= (k == 0) ? CSR_WIDTH : CSR_HEIGHT;
         csr_wdata <= COORD_W'((k == 0) ? w : h);
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic note_fail(input string msg);
      if (fail_count < 10) $display("%0t ns: %s", $time, msg);
      fail_count++;
   endtask

   // ---------------------------------------------------------------------
   // Monitor: register writes, command transfers and results, all sampled
   // on the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type seen, owed, model_rsp;
      if (reset) begin
         surf_w = WIDTH_RESET;
         surf_h = HEIGHT_RESET;
         foreach (tile_box[i]) tile_box[i] = '0;
      end else begin
         // a result lives one cycle only: take it now or lose it
         if (rsp_valid) begin
            seen = rsp_payload;
            if (rsp_due.size() == 0) begin
               note_fail($sformatf("result with nothing owed: dirty %0d (%0d,%0d) %0dx%0d",
                                   seen.tile_dirty, seen.box_x, seen.box_y,
                                   seen.box_w, seen.box_h));
            end else begin
               owed = rsp_due.pop_front();
               if (seen.tile_dirty !== owed.tile_dirty || seen.box_x !== owed.box_x ||
                   seen.box_y !== owed.box_y || seen.box_w !== owed.box_w ||
                   seen.box_h !== owed.box_h)
                  note_fail($sformatf({"result mismatch: expected dirty %0d (%0d,%0d) ",
                                       "%0dx%0d, got dirty %0d (%0d,%0d) %0dx%0d"},
                                      owed.tile_dirty, owed.box_x, owed.box_y,
                                      owed.box_w, owed.box_h, seen.tile_dirty,
                                      seen.box_x, seen.box_y, seen.box_w, seen.box_h));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WIDTH:  surf_w = csr_wdata;
               CSR_HEIGHT: surf_h = csr_wdata;
               default: ;
            endcase
         end
         // command transfer: the shadow grid moves on whether or not the
         // owed result was typed in
         if (start && !busy) begin
            model_rsp = run_command(req_payload);
            rsp_due.push_back(hold_pinned ? pinned_rsp : model_rsp);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      int i, ph, n;
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_WIDTH;
      csr_wdata   = '0;
      hold_pinned = 1'b0;
      pinned_rsp  = NO_BOX;
      fail_count  = 0;

      // directed part at the reset size of 640 x 480 (20 x 15 tiles)
      dir_rows = '{
         '{mk_read(0, 0),                               1'b1, NO_BOX},  // clean after reset
         '{mk_add(0, 0, 1, 1),                          1'b1, NO_BOX},
         '{mk_read(0, 0),                               1'b1, mk_box(0, 0, 1, 1)},
         '{mk_add(-32768, -32768, 65535, 65535),        1'b1, NO_BOX},  // clipped to screen
         '{mk_read(14, 19),                             1'b1, mk_box(608, 448, 32, 32)},
         '{mk_read(15, 0),                              1'b1, NO_BOX},  // below the grid
         '{mk_read(0, 20),                              1'b1, NO_BOX},  // right of the grid
         '{mk_read(31, 31),                             1'b1, NO_BOX},
         '{mk_op(CMD_CLEAR),                            1'b1, NO_BOX},
         '{mk_read(14, 19),                             1'b1, NO_BOX},
         '{mk_add(10, 10, 0, 5),                        1'b1, NO_BOX},  // zero width
         '{mk_add(10, 10, 5, 0),                        1'b1, NO_BOX},  // zero height
         '{mk_add(640, 0, 10, 10),                      1'b1, NO_BOX},  // right of screen
         '{mk_add(32767, 32767, 65535, 65535),          1'b1, NO_BOX},
         '{mk_add(0, -20, 10, 20),                      1'b1, NO_BOX},  // ends at the top
         '{mk_read(0, 0),                               1'b1, NO_BOX},  // empties left it clean
         '{mk_add(-5, -3, 10, 10),                      1'b1, NO_BOX},  // shortened by the clip
         '{mk_read(0, 0),                               1'b1, mk_box(0, 0, 5, 7)},
         '{mk_add(30, 30, 4, 4),                        1'b1, NO_BOX},  // four tiles
         '{mk_read(0, 0),                               1'b0, NO_BOX},
         '{mk_read(0, 1),                               1'b0, NO_BOX},
         '{mk_read(1, 1),                               1'b0, NO_BOX},
         '{mk_op(CMD_UNUSED),                           1'b1, NO_BOX},
         '{mk_add(639, 479, 1, 1),                      1'b1, NO_BOX},  // last pixel
         '{mk_read(14, 19),                             1'b0, NO_BOX},
         '{mk_add(0, 100, 65535, 1),                    1'b1, NO_BOX},  // one full row
         '{mk_read(3, 5),                               1'b0, NO_BOX}
      };

      // surface sizes per phase: reset size, full grid, one pixel, oversized
      // (capped), zero width, zero height, a narrow odd one, a random one and
      // the full grid again for the closing stretch without idling
      plan_w = '{640, 1024, 1, 2047, 0, 640, 33, 0, 1024};
      plan_h = '{480, 1024, 1, 2047, 480, 0, 1000, 0, 1024};
      plan_w[7] = $urandom_range(1, 1024);
      plan_h[7] = $urandom_range(1, 1024);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // the block clears its store after reset with busy high; the first
      // transfer simply waits that out
      for (i = 0; i < $size(dir_rows); i++) begin
         if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 4));
         issue(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].want);
      end

      for (ph = 0; ph < N_PHASES; ph++) begin
         wait_quiet();
         set_surface(plan_w[ph], plan_h[ph]);
         for (n = 0; n < PHASE_LEN; n++) begin
            // mid-phase the sender holds off until the block has caught up
            if (ph < N_PHASES - 1 && n == PHASE_LEN / 2) wait_quiet();
            if (ph < N_PHASES - 1 && $urandom_range(0, 4) == 0)
               idle_cycles($urandom_range(1, 4));
            issue(random_cmd(), 1'b0, NO_BOX);
         end
      end

      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0 && rsp_due.size() == 0) begin
         $display("microtile_dirty_region_tracker test passed");
      end else begin
         $display("microtile_dirty_region_tracker test failed");
      end
      $finish;
   end

   // hard stop should the block hang
   initial begin
      #(RUN_LIMIT_NS);
      $display("microtile_dirty_region_tracker test failed");
      $finish;
   end

endmodule

/* files.f */
rtl/core/mdrt_pkg.sv
rtl/core/mdrt_tile_ram.sv
rtl/core/mdrt_clip.sv
rtl/core/mdrt_merge.sv
rtl/core/microtile_dirty_region_tracker.sv
rtl/core/mdrt_checker.sv
test/tb_top.sv
